/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the string unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/jsu_pkg.sv */
// Types and constants of the JSON string unescaper.
package jsu_pkg;

   localparam int MaxResults = 4;

   localparam logic [1:0] KIND_DATA         = 2'd0;
   localparam logic [1:0] KIND_CLOSED       = 2'd1;
   localparam logic [1:0] KIND_NO_QUOTE     = 2'd2;
   localparam logic [1:0] KIND_UNTERMINATED = 2'd3;

   localparam logic [1:0] MODE_AWAIT  = 2'd0;
   localparam logic [1:0] MODE_STRING = 2'd1;
   localparam logic [1:0] MODE_ESCAPE = 2'd2;
   localparam logic [1:0] MODE_HEX    = 2'd3;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;

   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;
   localparam logic [7:0]  UTF8_MASK  = 8'h3F;
   localparam logic [15:0] UTF8_TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [15:0] UTF8_ONE_BYTE_LIMIT = 16'h0080;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] code_point;
      logic [1:0]  hex_count;
   } state_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
   } entry_type;

   typedef struct packed {
      entry_type [MaxResults-1:0] entry;
      logic [2:0]                 count;
   } burst_type;

endpackage

/* hdl/jsu_req_if.sv */
// Handshake interface that carries raw input bytes.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* hdl/jsu_rsp_if.sv */
// Handshake interface that carries decoded results.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] result_kind;
   logic       run_last;

   modport source (output valid, output out_byte, output result_kind, output run_last,
                   input ready);
   modport sink (input valid, input out_byte, input result_kind, input run_last,
                 output ready);
endinterface

/* hdl/jsu_decode.sv */
// Combinational decode of one input byte into a burst of results and the next state.
module jsu_decode
   import jsu_pkg::*;
(
   input  state_type  state,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output state_type  state_next,
   output burst_type  burst
);

   function automatic logic [3:0] hex_value(input logic [7:0] h);
      logic [3:0] v;
      v = 4'd0;
      if (h >= 8'h30 && h <= 8'h39) begin
         v = h[3:0];
      end else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46)) begin
         v = h[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CHAR_LOWER_N: r = CHAR_NEWLINE;
         CHAR_LOWER_T: r = CHAR_TAB;
         CHAR_LOWER_R: r = CHAR_RETURN;
         default:      r = b;
      endcase
      return r;
   endfunction

   always_comb begin
      logic [2:0]  n;
      logic        closed;
      logic [15:0] cp;
      n      = 3'd0;
      closed = 1'b0;
      cp     = {state.code_point[11:0], hex_value(in_byte)};
      state_next = state;
      burst      = '0;

      case (state.mode)
         MODE_AWAIT: begin
            if (in_byte == CHAR_QUOTE) begin
               state_next.mode = MODE_STRING;
            end else begin
               burst.entry[n[1:0]] = '{data: 8'd0, kind: KIND_NO_QUOTE};
               n      = n + 3'd1;
               closed = 1'b1;
            end
         end
         MODE_STRING: begin
            if (in_byte == CHAR_BACKSLASH) begin
               if (in_last) begin
                  burst.entry[n[1:0]] = '{data: in_byte, kind: KIND_DATA};
                  n = n + 3'd1;
               end else begin
                  state_next.mode = MODE_ESCAPE;
               end
            end else if (in_byte == CHAR_QUOTE) begin
               burst.entry[n[1:0]] = '{data: 8'd0, kind: KIND_CLOSED};
               n      = n + 3'd1;
               closed = 1'b1;
               state_next.mode = MODE_AWAIT;
            end else begin
               burst.entry[n[1:0]] = '{data: in_byte, kind: KIND_DATA};
               n = n + 3'd1;
            end
         end
         MODE_ESCAPE: begin
            if (in_byte == CHAR_LOWER_U) begin
               state_next.mode       = MODE_HEX;
               state_next.code_point = '0;
               state_next.hex_count  = '0;
            end else begin
               burst.entry[n[1:0]] = '{data: unescape(in_byte), kind: KIND_DATA};
               n = n + 3'd1;
               state_next.mode = MODE_STRING;
            end
         end
         default: begin
            if (state.hex_count == 2'd3) begin
               if (cp < UTF8_ONE_BYTE_LIMIT) begin
                  burst.entry[0] = '{data: cp[7:0], kind: KIND_DATA};
                  n = 3'd1;
               end else if (cp < UTF8_TWO_BYTE_LIMIT) begin
                  burst.entry[0] = '{data: UTF8_LEAD2 | {3'd0, cp[10:6]}, kind: KIND_DATA};
                  burst.entry[1] = '{data: UTF8_CONT | ({2'd0, cp[5:0]} & UTF8_MASK),
                                     kind: KIND_DATA};
                  n = 3'd2;
               end else begin
                  burst.entry[0] = '{data: UTF8_LEAD3 | {4'd0, cp[15:12]}, kind: KIND_DATA};
                  burst.entry[1] = '{data: UTF8_CONT | ({2'd0, cp[11:6]} & UTF8_MASK),
                                     kind: KIND_DATA};
                  burst.entry[2] = '{data: UTF8_CONT | ({2'd0, cp[5:0]} & UTF8_MASK),
                                     kind: KIND_DATA};
                  n = 3'd3;
               end
               state_next.mode       = MODE_STRING;
               state_next.code_point = '0;
               state_next.hex_count  = '0;
            end else begin
               state_next.code_point = cp;
               state_next.hex_count  = state.hex_count + 2'd1;
            end
         end
      endcase

      if (in_last && !closed) begin
         burst.entry[n[1:0]] = '{data: 8'd0, kind: KIND_UNTERMINATED};
         n = n + 3'd1;
         state_next.mode       = MODE_AWAIT;
         state_next.code_point = '0;
         state_next.hex_count  = '0;
      end

      burst.count = n;
   end

endmodule

/* hdl/json_string_unescaper_top.sv */
// Top level of the JSON string unescaper: decode state and the result burst buffer.
//
// The req channel carries one raw byte per transaction with in_last marking the end
// of the available input. The rsp channel carries zero to four results per input
// byte: decoded data bytes, a string-closed mark, a missing-quote mark or an
// unterminated mark, with run_last set on the final result of each input byte.
// An accepted byte is decoded in the same cycle and its results are written into
// a four-entry burst register; the first result is offered on rsp in the next
// cycle. Results leave one per cycle while the receiver is ready. A new byte is
// taken while the last result of the previous burst is being handed off, so with
// the receiver ready a stream of bytes that each give at most one result flows at
// one byte per cycle. Bytes that give no result (an opening quote, a backslash, a
// hex digit before the fourth) leave nothing on rsp. Reset is synchronous: the
// block waits for an opening quote with an empty burst register. When the
// receiver stalls, the current result holds and req_ch.ready drops until the
// burst is down to its last result being taken.
module json_string_unescaper_top
   import jsu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);

`include "assert_macros.svh"

   state_type                  state_ff, state_in;
   entry_type [MaxResults-1:0] buf_ff, buf_in;
   logic [2:0]                 rem_ff, rem_in;
   logic [1:0]                 idx_ff, idx_in;
   state_type                  state_dec;
   burst_type                  burst;
   logic                       req_fire, rsp_fire;

   jsu_decode u_decode (
      .state      (state_ff),
      .in_byte    (req_ch.in_byte),
      .in_last    (req_ch.in_last),
      .state_next (state_dec),
      .burst      (burst)
   );

   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = (rem_ff != 3'd0);
   assign rsp_ch.out_byte    = buf_ff[idx_ff].data;
   assign rsp_ch.result_kind = buf_ff[idx_ff].kind;
   assign rsp_ch.run_last    = (rem_ff == 3'd1);

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      if (req_fire) begin
         state_in = state_dec;
         buf_in   = burst.entry;
         rem_in   = burst.count;
         idx_in   = 2'd0;
      end else if (rsp_fire) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_AWAIT, code_point: 16'd0, hex_count: 2'd0};
         rem_ff   <= 3'd0;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         idx_ff   <= idx_in;
      end
      buf_ff <= buf_in;
   end

   `ASSERT_SAME(a_rem_range, 1'b1, rem_ff <= 3'd4)
   `ASSERT_SAME(a_idx_within_burst, rsp_ch.valid, ({1'b0, idx_ff} + rem_ff) <= 3'd4)
   `ASSERT_SAME(a_no_overwrite, req_fire, (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_fire))
   `ASSERT_SAME(a_marks_carry_zero, rsp_ch.valid && rsp_ch.result_kind != KIND_DATA,
                rsp_ch.out_byte == 8'd0)
   `ASSERT_NEXT(a_hex_count_idle, state_ff.mode != MODE_HEX && !req_fire,
                $stable(state_ff.hex_count))

endmodule

/* sim/tb_json_string_unescaper_top.sv */
// Testbench for the JSON string unescaper: directed and random byte streams checked against a decoder.
module tb_json_string_unescaper_top;
   import jsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 1000;
   localparam int RandomItems   = 270;

   typedef struct {
      logic [7:0] in_byte;
      logic       in_last;
   } raw_byte_type;

   typedef struct {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       run_last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jsu_req_if req_if ();
   jsu_rsp_if rsp_if ();

   raw_byte_type raw_bytes[$];
   result_type   decoded_out[$];
   result_type   want;

   logic [1:0]  dec_mode = MODE_AWAIT;
   logic [15:0] dec_cp = '0;
   logic [2:0]  dec_hex_n = '0;

   int   mismatches = 0;
   int   quiet_cycles = 0;
   int   send_gap = 0;
   int   hold_gap = 0;
   logic req_taken = 1'b0;
   logic pace_send = 1'b1;
   logic pace_recv = 1'b1;
   logic calm_end = 1'b0;

   json_string_unescaper_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type make_result(input logic [7:0] data, input logic [1:0] kind);
      result_type r;
      r.out_byte = data;
      r.kind = kind;
      r.run_last = 1'b0;
      return r;
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (b >= "0" && b <= "9") v = b - 8'h30;
      else if (b >= "a" && b <= "f") v = b - 8'h57;
      else if (b >= "A" && b <= "F") v = b - 8'h37;
      return v[3:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) c = 8'h30 + {4'h0, n};
      else if ($urandom_range(0, 1) == 0) c = 8'h57 + {4'h0, n};
      else c = 8'h37 + {4'h0, n};
      return c;
   endfunction

   task automatic unescape_byte(input logic [7:0] b, input logic last);
      result_type burst[$];
      logic       stop;
      stop = 1'b0;
      case (dec_mode)
         MODE_AWAIT: begin
            if (b == CHAR_QUOTE) begin
               dec_mode = MODE_STRING;
            end else begin
               burst = {burst, make_result(8'h00, KIND_NO_QUOTE)};
               stop = 1'b1;
            end
         end
         MODE_STRING: begin
            if (b == CHAR_BACKSLASH) begin
               if (last) burst = {burst, make_result(b, KIND_DATA)};
               else dec_mode = MODE_ESCAPE;
            end else if (b == CHAR_QUOTE) begin
               burst = {burst, make_result(8'h00, KIND_CLOSED)};
               dec_mode = MODE_AWAIT;
               stop = 1'b1;
            end else begin
               burst = {burst, make_result(b, KIND_DATA)};
            end
         end
         MODE_ESCAPE: begin
            if (b == CHAR_LOWER_U) begin
               dec_mode = MODE_HEX;
               dec_cp = '0;
               dec_hex_n = '0;
            end else begin
               case (b)
                  CHAR_LOWER_N: burst = {burst, make_result(CHAR_NEWLINE, KIND_DATA)};
                  CHAR_LOWER_T: burst = {burst, make_result(CHAR_TAB, KIND_DATA)};
                  CHAR_LOWER_R: burst = {burst, make_result(CHAR_RETURN, KIND_DATA)};
                  default:      burst = {burst, make_result(b, KIND_DATA)};
               endcase
               dec_mode = MODE_STRING;
            end
         end
         default: begin
            dec_cp = {dec_cp[11:0], hex_nibble(b)};
            dec_hex_n = dec_hex_n + 3'd1;
            if (dec_hex_n >= 3'd4) begin
               if (dec_cp < UTF8_ONE_BYTE_LIMIT) begin
                  burst = {burst, make_result(dec_cp[7:0], KIND_DATA)};
               end else if (dec_cp < UTF8_TWO_BYTE_LIMIT) begin
                  burst = {burst, make_result(UTF8_LEAD2 | {3'b000, dec_cp[10:6]}, KIND_DATA)};
                  burst = {burst, make_result(UTF8_CONT | {2'b00, dec_cp[5:0]}, KIND_DATA)};
               end else begin
                  burst = {burst, make_result(UTF8_LEAD3 | {4'h0, dec_cp[15:12]}, KIND_DATA)};
                  burst = {burst, make_result(UTF8_CONT | {2'b00, dec_cp[11:6]}, KIND_DATA)};
                  burst = {burst, make_result(UTF8_CONT | {2'b00, dec_cp[5:0]}, KIND_DATA)};
               end
               dec_mode = MODE_STRING;
               dec_cp = '0;
               dec_hex_n = '0;
            end
         end
      endcase
      if (last && !stop) begin
         burst = {burst, make_result(8'h00, KIND_UNTERMINATED)};
         dec_mode = MODE_AWAIT;
         dec_cp = '0;
         dec_hex_n = '0;
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i]) decoded_out = {decoded_out, burst[i]};
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic last);
      raw_byte_type t;
      t.in_byte = b;
      t.in_last = last;
      raw_bytes = {raw_bytes, t};
   endtask

   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (raw_bytes.size() > 0 && !calm_end && pace_send &&
                      $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(0, 8);
            req_if.valid <= 1'b0;
         end else if (raw_bytes.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.in_byte <= raw_bytes[0].in_byte;
            req_if.in_last <= raw_bytes[0].in_last;
            raw_bytes.delete(0);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      if ($urandom_range(0, 59) == 0) pace_send <= !pace_send;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_gap > 0) begin
         hold_gap <= hold_gap - 1;
         rsp_if.ready <= 1'b0;
      end else if (!calm_end && pace_recv && $urandom_range(0, 3) == 0) begin
         hold_gap <= $urandom_range(0, 8);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 59) == 0) pace_recv <= !pace_recv;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (decoded_out.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %h kind=%0d last=%b",
                        $time, rsp_if.out_byte, rsp_if.result_kind, rsp_if.run_last);
            end else begin
               want = decoded_out.pop_front();
               if (rsp_if.out_byte !== want.out_byte) begin
                  mismatches++;
                  $display("%0t: out_byte mismatch, expected %h, actual %h",
                           $time, want.out_byte, rsp_if.out_byte);
               end
               if (rsp_if.result_kind !== want.kind) begin
                  mismatches++;
                  $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                           $time, want.kind, rsp_if.result_kind);
               end
               if (rsp_if.run_last !== want.run_last) begin
                  mismatches++;
                  $display("%0t: run_last mismatch, expected %b, actual %b",
                           $time, want.run_last, rsp_if.run_last);
               end
            end
         end
         if (req_if.valid && req_if.ready) unescape_byte(req_if.in_byte, req_if.in_last);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [7:0]  seq[$];
      logic [15:0] cp;
      logic        end_last;
      int          cut;
      int          n;

      req_if.valid = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.in_last = 1'b0;
      rsp_if.ready = 1'b0;

      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(CHAR_QUOTE, 1'b1);
      queue_byte(CHAR_QUOTE, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(CHAR_LOWER_N, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(CHAR_QUOTE, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte("q", 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b1);
      queue_byte(CHAR_QUOTE, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(CHAR_LOWER_U, 1'b0);
      queue_byte("F", 1'b0);
      queue_byte("e", 1'b0);
      queue_byte("0", 1'b0);
      queue_byte("g", 1'b1);
      queue_byte(CHAR_QUOTE, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(CHAR_LOWER_U, 1'b0);
      queue_byte("0", 1'b0);
      queue_byte("7", 1'b1);
      queue_byte(CHAR_QUOTE, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(CHAR_QUOTE, 1'b0);
      queue_byte(CHAR_QUOTE, 1'b1);

      while (raw_bytes.size() < RandomItems) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end else begin
            seq.delete();
            seq = {seq, CHAR_QUOTE};
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: begin
                     if ($urandom_range(0, 1) == 0) seq = {seq, 8'($urandom_range(8'h20, 8'h7E))};
                     else seq = {seq, 8'($urandom_range(0, 255))};
                  end
                  5, 6, 7: begin
                     seq = {seq, CHAR_BACKSLASH};
                     case ($urandom_range(0, 6))
                        0: seq = {seq, CHAR_LOWER_N};
                        1: seq = {seq, CHAR_LOWER_T};
                        2: seq = {seq, CHAR_LOWER_R};
                        3: seq = {seq, CHAR_QUOTE};
                        4: seq = {seq, CHAR_BACKSLASH};
                        5: seq = {seq, 8'h2F};
                        default: seq = {seq, 8'($urandom_range(0, 255))};
                     endcase
                  end
                  default: begin
                     case ($urandom_range(0, 2))
                        0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                     endcase
                     seq = {seq, CHAR_BACKSLASH};
                     seq = {seq, CHAR_LOWER_U};
                     for (int d = 3; d >= 0; d--) begin
                        if ($urandom_range(0, 9) == 0) seq = {seq, 8'($urandom_range(0, 255))};
                        else seq = {seq, hex_char(cp[d*4 +: 4])};
                     end
                  end
               endcase
            end
            if ($urandom_range(0, 9) < 7) begin
               seq = {seq, CHAR_QUOTE};
               end_last = ($urandom_range(0, 3) == 0);
            end else begin
               cut = int'($urandom_range(0, seq.size() - 1));
               seq = seq[0:cut];
               end_last = 1'b1;
            end
            foreach (seq[i]) queue_byte(seq[i], (i == seq.size() - 1) ? end_last : 1'b0);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (raw_bytes.size() >= 40) @(posedge clock);
      calm_end = 1'b1;
      while (raw_bytes.size() != 0 || req_if.valid) @(posedge clock);
      while (decoded_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && decoded_out.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
